### hdl/fdp_pkg.sv
// Shared types and constants for the fractional divider parameter block.
package fdp_pkg;

   localparam int FRAC_W = 20;
   localparam logic [FRAC_W-1:0] FRAC_MAX = 20'hFFFFF;
   localparam int INT_W = 11;
   localparam int P1_W = 18;
   localparam int DIV_W = 64;
   localparam int DIV_CW = 6;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_ZERO_DEN = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_CHECK,
      ST_GCD,
      ST_GCD_STEP,
      ST_RED_B,
      ST_RED_C,
      ST_SCALE,
      ST_SCALE_DONE,
      ST_FT,
      ST_PACK,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic start;
      logic [DIV_W-1:0] hi;
      logic [DIV_W-1:0] lo;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [DIV_W-1:0] quot;
      logic [DIV_W-1:0] rem;
   } div_rsp_type;

endpackage

### hdl/fdp_serial_div.sv
// Restoring bit-serial divider: 128-by-64 bit division, one quotient bit per cycle.
module fdp_serial_div
   import fdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIV_W-1:0] hi_ff, hi_in, lo_ff, lo_in, den_ff, den_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic carry;
   logic [DIV_W-1:0] sh;
   logic [DIV_W:0] diff;

   always_comb begin
      hi_in = hi_ff;
      lo_in = lo_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      carry = hi_ff[DIV_W-1];
      sh = {hi_ff[DIV_W-2:0], lo_ff[DIV_W-1]};
      diff = {1'b0, sh} - {1'b0, den_ff};
      if (req.start) begin
         hi_in = req.hi;
         lo_in = req.lo;
         den_in = req.den;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (carry || !diff[DIV_W]) begin
            hi_in = diff[DIV_W-1:0];
            lo_in = {lo_ff[DIV_W-2:0], 1'b1};
         end else begin
            hi_in = sh;
            lo_in = {lo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = lo_ff;
   assign rsp.rem = hi_ff;

`ifndef SYNTHESIS
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && !req.start) |=> !busy_ff) else $error("spurious busy");
`endif

endmodule

### hdl/fractional_divider_params_core.sv
// Top level of the fractional divider parameter calculator.
// Usage: present a ratio N/D and inclusive integer bounds on the req_ channel
// (valid/ready). One result per request leaves on the rsp_ channel.
// Each transaction is worked by a sequencer around one bit-serial divider.
// Divisions per transaction: none for a zero denominator, one for an
// out-of-range integer part; otherwise one for the split, one per Euclid
// step (at most about 47 for 32-bit ratios, 93 for 64-bit), 2 for the
// reduction (both skipped when the remainder is zero), and when rescaling
// is needed one more, a second GCD of at most about 31 steps and its
// reduction; then one for floor(128b/c).
// Throughput: one transaction at a time; req_ready is high only while idle
// with no result waiting, so the next request is taken the cycle after the
// previous result is accepted.
// Reset: synchronous, active high; clears the sequencer and rsp_valid.
// Stall: the result holds on rsp_ ports until rsp_ready, and no request is
// accepted meanwhile.
module fractional_divider_params_core
   import fdp_pkg::*;
#(
   parameter int RATIO_WIDTH = 32
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [RATIO_WIDTH-1:0] req_ratio_numerator,
   input  logic [RATIO_WIDTH-1:0] req_ratio_denominator,
   input  logic [INT_W-1:0]       req_min_integer,
   input  logic [INT_W-1:0]       req_max_integer,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [INT_W-1:0]       rsp_whole_part,
   output logic [FRAC_W-1:0]      rsp_frac_numerator,
   output logic [FRAC_W-1:0]      rsp_frac_denominator,
   output logic [P1_W-1:0]        rsp_param_one,
   output logic [FRAC_W-1:0]      rsp_param_two,
   output logic [FRAC_W-1:0]      rsp_param_three,
   output logic [63:0]            rsp_register_image
);

   state_type state_ff, state_in;
   logic [DIV_W-1:0] num_ff, num_in, den_ff, den_in, a_ff, a_in;
   logic [DIV_W-1:0] x_ff, x_in, y_ff, y_in, b_ff, b_in, c_ff, c_in;
   logic [INT_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic scaled_ff, scaled_in;
   logic rv_ff, rv_in;
   logic [1:0] st_ff, st_in;
   logic [INT_W-1:0] ao_ff, ao_in;
   logic [FRAC_W-1:0] bo_ff, bo_in, co_ff, co_in, p2_ff, p2_in;
   logic [P1_W-1:0] p1_ff, p1_in;
   div_req_type dq;
   div_rsp_type dr;
   logic [DIV_W-1:0] phi, plo, t, ft;
   logic [FRAC_W+7:0] b128, cft;

   fdp_serial_div u_div (.clock(clock), .reset(reset), .req(dq), .rsp(dr));

   assign req_ready = (state_ff == ST_IDLE) && !rv_ff;

   always_comb begin
      state_in = state_ff;
      num_in = num_ff; den_in = den_ff; a_in = a_ff;
      x_in = x_ff; y_in = y_ff; b_in = b_ff; c_in = c_ff;
      lo_in = lo_ff; hi_in = hi_ff; scaled_in = scaled_ff;
      rv_in = rv_ff; st_in = st_ff; ao_in = ao_ff; bo_in = bo_ff;
      co_in = co_ff; p1_in = p1_ff; p2_in = p2_ff;
      dq = '0;
      t = b_ff << 20;
      phi = b_ff >> 44;
      plo = t - b_ff;
      if (t < b_ff) phi = phi - 1'b1;
      t = plo + (c_ff >> 1);
      if (t < plo) phi = phi + 1'b1;
      plo = t;
      ft = dr.quot;
      b128 = {1'b0, b_ff[FRAC_W-1:0], 7'd0};
      cft = (FRAC_W+8)'(c_ff[FRAC_W-1:0] * ft[7:0]);
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               num_in = DIV_W'(req_ratio_numerator);
               den_in = DIV_W'(req_ratio_denominator);
               lo_in = req_min_integer;
               hi_in = req_max_integer;
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            if (den_ff == '0) begin
               st_in = STATUS_ZERO_DEN;
               state_in = ST_HOLD;
            end else begin
               dq.start = 1'b1; dq.hi = '0; dq.lo = num_ff; dq.den = den_ff;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (dr.done) begin
               a_in = dr.quot;
               scaled_in = 1'b0;
               if (dr.quot < DIV_W'(lo_ff) || dr.quot > DIV_W'(hi_ff)) begin
                  st_in = STATUS_RANGE;
                  state_in = ST_HOLD;
               end else if (dr.rem == '0) begin
                  b_in = '0; c_in = 64'd1;
                  state_in = ST_FT;
               end else begin
                  b_in = dr.rem; c_in = den_ff;
                  x_in = dr.rem; y_in = den_ff;
                  state_in = ST_GCD;
               end
            end
         end
         ST_GCD: begin
            if (y_ff == '0) begin
               dq.start = 1'b1; dq.hi = '0; dq.lo = b_ff; dq.den = x_ff;
               state_in = ST_RED_B;
            end else begin
               dq.start = 1'b1; dq.hi = '0; dq.lo = x_ff; dq.den = y_ff;
               state_in = ST_GCD_STEP;
            end
         end
         ST_GCD_STEP: begin
            if (dr.done) begin
               x_in = y_ff; y_in = dr.rem;
               state_in = ST_GCD;
            end
         end
         ST_RED_B: begin
            if (dr.done) begin
               b_in = dr.quot;
               dq.start = 1'b1; dq.hi = '0; dq.lo = c_ff; dq.den = x_ff;
               state_in = ST_RED_C;
            end
         end
         ST_RED_C: begin
            if (dr.done) begin
               c_in = dr.quot;
               if (!scaled_ff && dr.quot > DIV_W'(FRAC_MAX)) state_in = ST_SCALE;
               else state_in = ST_FT;
            end
         end
         ST_SCALE: begin
            dq.start = 1'b1; dq.hi = phi; dq.lo = plo; dq.den = c_ff;
            state_in = ST_SCALE_DONE;
         end
         ST_SCALE_DONE: begin
            if (dr.done) begin
               scaled_in = 1'b1;
               c_in = DIV_W'(FRAC_MAX);
               if (dr.quot >= DIV_W'(FRAC_MAX)) b_in = DIV_W'(FRAC_MAX) - 1'b1;
               else b_in = dr.quot;
               x_in = (dr.quot >= DIV_W'(FRAC_MAX)) ? DIV_W'(FRAC_MAX) - 1'b1
                                                     : dr.quot;
               y_in = DIV_W'(FRAC_MAX);
               state_in = ST_GCD;
            end
         end
         ST_FT: begin
            dq.start = 1'b1; dq.hi = '0;
            dq.lo = {b_ff[DIV_W-8:0], 7'd0}; dq.den = c_ff;
            state_in = ST_PACK;
         end
         ST_PACK: begin
            if (dr.done) begin
               st_in = STATUS_OK;
               ao_in = a_ff[INT_W-1:0];
               bo_in = b_ff[FRAC_W-1:0];
               co_in = c_ff[FRAC_W-1:0];
               p1_in = P1_W'({a_ff[INT_W-1:0], 7'd0}) + P1_W'(ft) - P1_W'(512);
               p2_in = FRAC_W'(b128 - cft);
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_HOLD: begin
            ao_in = '0; bo_in = '0; co_in = '0; p1_in = '0; p2_in = '0;
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in; den_ff <= den_in; a_ff <= a_in;
      x_ff <= x_in; y_ff <= y_in; b_ff <= b_in; c_ff <= c_in;
      lo_ff <= lo_in; hi_ff <= hi_in; scaled_ff <= scaled_in;
      st_ff <= st_in; ao_ff <= ao_in; bo_ff <= bo_in; co_ff <= co_in;
      p1_ff <= p1_in; p2_ff <= p2_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_whole_part = ao_ff;
   assign rsp_frac_numerator = bo_ff;
   assign rsp_frac_denominator = co_ff;
   assign rsp_param_one = p1_ff;
   assign rsp_param_two = p2_ff;
   assign rsp_param_three = co_ff;
   assign rsp_register_image = {co_ff[15:8], co_ff[7:0], 6'd0, p1_ff[17:16],
                                p1_ff[15:8], p1_ff[7:0], co_ff[19:16], p2_ff[19:16],
                                p2_ff[15:8], p2_ff[7:0]};

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("ready while busy");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp_ready) |=> (rv_ff && $stable(p1_ff) && $stable(st_ff)))
      else $error("result dropped");
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && st_ff == STATUS_OK) |-> (co_ff != '0)) else $error("zero c");
`endif

endmodule
